>>> design/avr_pkg.sv
package avr_pkg;

   // Q30 constants for the CORDIC
   localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
   localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
   localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;
   localparam logic signed [34:0] Q30_ONE     = 35'sd1073741824;
   localparam int                 MAX_STAGES  = 32;

   typedef struct packed {
      logic signed [15:0] turn_angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic signed [31:0] view_x;
      logic signed [31:0] view_y;
      logic signed [31:0] view_z;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_view_x;
      logic signed [31:0] new_view_y;
      logic signed [31:0] new_view_z;
      logic               saturated;
   } rsp_type;

   // data handed from cell to cell and into the matrix unit
   typedef struct packed {
      logic signed [33:0]      x;
      logic signed [33:0]      y;
      logic signed [33:0]      z;
      logic                    flip;
      logic signed [2:0][15:0] a;
      logic signed [2:0][32:0] d;
      logic signed [2:0][31:0] p;
   } cordic_type;

   // arctangent table, Q30
   function automatic logic signed [33:0] atan_q30(input int idx);
      logic signed [33:0] v;
      case (idx)
         0: v = 34'sd843314857;
         1: v = 34'sd497837829;
         2: v = 34'sd263043836;
         3: v = 34'sd133525158;
         4: v = 34'sd67021686;
         5: v = 34'sd33543515;
         6: v = 34'sd16775850;
         7: v = 34'sd8388437;
         8: v = 34'sd4194282;
         9: v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         24: v = 34'sd63;
         25: v = 34'sd31;
         26: v = 34'sd15;
         27: v = 34'sd8;
         28: v = 34'sd4;
         29: v = 34'sd2;
         30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

>>> design/avr_cordic_cell.sv
module avr_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  avr_pkg::cordic_type in_data,
   output logic                up_ready,
   output logic                out_valid,
   output avr_pkg::cordic_type out_data,
   input  logic                down_ready
);
   import avr_pkg::*;

   localparam logic signed [33:0] ATAN = atan_q30(STAGE);

   logic       valid_ff;
   cordic_type data_ff;
   cordic_type data_in;

   // one micro-rotation
   always_comb begin
      data_in = in_data;
      if (in_data.z >= 0) begin
         data_in.x = in_data.x - (in_data.y >>> STAGE);
         data_in.y = in_data.y + (in_data.x >>> STAGE);
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + (in_data.y >>> STAGE);
         data_in.y = in_data.y - (in_data.x >>> STAGE);
         data_in.z = in_data.z + ATAN;
      end
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

>>> design/avr_matrix.sv
module avr_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  avr_pkg::cordic_type in_data,
   output logic                up_ready,
   output logic                rsp_valid,
   output avr_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);
   import avr_pkg::*;

   localparam int NST = 5;

   logic [NST-1:0] valid_ff;
   logic [NST:0]   ready;

   // stage handshake: a stage loads when empty or when it drains
   always_comb begin
      ready[NST] = !rsp_stall;
      for (int i = NST - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end
   assign up_ready = ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff[0] <= ready[0] ? in_valid : valid_ff[0];
         for (int i = 1; i < NST; i++) begin
            if (ready[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // stage 1: t*a and a*s
   logic signed [33:0] c_w, s_w, c1_ff, c2_ff;
   logic signed [34:0] t_w;
   logic signed [36:0] ta_in [3], ta_ff [3];
   logic signed [35:0] as_in [3], as1_ff [3], as2_ff [3];
   logic signed [15:0] a1_ff [3];
   logic signed [32:0] d1_ff [3], d2_ff [3], d3_ff [3];
   logic signed [31:0] p1_ff [3], p2_ff [3], p3_ff [3], p4_ff [3];
   logic signed [50:0] pt [3];
   logic signed [49:0] ps [3];

   always_comb begin
      c_w = in_data.flip ? -in_data.x : in_data.x;
      s_w = in_data.flip ? -in_data.y : in_data.y;
      t_w = Q30_ONE - 35'(c_w);
      for (int k = 0; k < 3; k++) begin
         // elements of the packed axis array read as unsigned
         pt[k] = t_w * $signed(in_data.a[k]);
         pt[k] = pt[k] + 51'sd8192;
         ta_in[k] = pt[k][50:14];
         ps[k] = s_w * $signed(in_data.a[k]);
         ps[k] = ps[k] + 50'sd8192;
         as_in[k] = ps[k][49:14];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0] && in_valid) begin
         c1_ff <= c_w;
         for (int k = 0; k < 3; k++) begin
            ta_ff[k]  <= ta_in[k];
            as1_ff[k] <= as_in[k];
            a1_ff[k]  <= in_data.a[k];
            d1_ff[k]  <= in_data.d[k];
            p1_ff[k]  <= in_data.p[k];
         end
      end
   end

   // stage 2: outer product terms
   logic signed [52:0] pm [3][3];
   logic signed [38:0] m_in [3][3], m_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            pm[r][k] = ta_ff[r] * a1_ff[k];
            pm[r][k] = pm[r][k] + 53'sd8192;
            m_in[r][k] = pm[r][k][52:14];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1] && valid_ff[0]) begin
         c2_ff <= c1_ff;
         m_ff  <= m_in;
         for (int k = 0; k < 3; k++) begin
            as2_ff[k] <= as1_ff[k];
            d2_ff[k]  <= d1_ff[k];
            p2_ff[k]  <= p1_ff[k];
         end
      end
   end

   // stage 3: diagonal cosine, skew sine terms, reduce to Q25
   logic signed [40:0] full [3][3];
   logic signed [40:0] skew [3][3];
   logic signed [35:0] e_in [3][3], e_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            skew[r][k] = '0;
         end
         skew[r][r] = 41'(c2_ff);
      end
      skew[0][1] = -41'(as2_ff[2]);
      skew[1][0] =  41'(as2_ff[2]);
      skew[0][2] =  41'(as2_ff[1]);
      skew[2][0] = -41'(as2_ff[1]);
      skew[1][2] = -41'(as2_ff[0]);
      skew[2][1] =  41'(as2_ff[0]);
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            full[r][k] = 41'(m_ff[r][k]) + skew[r][k] + 41'sd16;
            e_in[r][k] = full[r][k][40:5];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[2] && valid_ff[1]) begin
         e_ff <= e_in;
         for (int k = 0; k < 3; k++) begin
            d3_ff[k] <= d2_ff[k];
            p3_ff[k] <= p2_ff[k];
         end
      end
   end

   // stage 4: entry times direction
   logic signed [68:0] prod_in [3][3], prod_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[r][k] = e_ff[r][k] * d3_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3] && valid_ff[2]) begin
         prod_ff <= prod_in;
         for (int k = 0; k < 3; k++) begin
            p4_ff[k] <= p3_ff[k];
         end
      end
   end

   // stage 5: row sums, round, add position, saturate
   logic signed [70:0] acc [3];
   logic signed [46:0] sum [3];
   logic signed [31:0] comp [3];
   logic [2:0]         hit;
   rsp_type            out_in, out_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc[r] = 71'(prod_ff[r][0]) + 71'(prod_ff[r][1]) + 71'(prod_ff[r][2])
                  + 71'sd16777216;
         sum[r] = 47'($signed(acc[r][70:25])) + 47'(p4_ff[r]);
         hit[r] = 1'b1;
         if (sum[r] > 47'sd2147483647) begin
            comp[r] = 32'sh7fffffff;
         end else if (sum[r] < -47'sd2147483648) begin
            comp[r] = 32'sh80000000;
         end else begin
            comp[r] = sum[r][31:0];
            hit[r]  = 1'b0;
         end
      end
      out_in.new_view_x = comp[0];
      out_in.new_view_y = comp[1];
      out_in.new_view_z = comp[2];
      out_in.saturated  = |hit;
   end

   always_ff @(posedge clock) begin
      if (ready[4] && valid_ff[3]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[4];
   assign rsp_data  = out_ff;
endmodule

>>> design/axis_angle_vector_rotate_top.sv
// Axis-angle view rotation. Each request transaction carries an eye position,
// a view point, a unit axis (Q2.14) and an angle (Q3.13 rad); the response
// transaction returns position + R*(view - position), saturated to 32 bits,
// with a flag raised when any component was clamped.
// Channels: req_* and rsp_* use valid/stall; a transaction moves on an edge
// with valid high and stall low.
// Pipeline: one front register for angle reduction and the direction, one cell
// per CORDIC iteration, five matrix/product stages with the last one as output
// register. One transaction per cycle while the receiver does not stall; each
// register stage loads whenever it is empty or drains, so bubbles collapse.
// When the receiver stalls, the response holds and the pipeline keeps
// filling; req_stall rises only once every stage holds a transaction.
// Reset clears all stage valid bits; no response is pending after reset.
module axis_angle_vector_rotate_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  avr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output avr_pkg::rsp_type rsp_data
);
   import avr_pkg::*;

   localparam int N = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

   logic       front_valid_ff;
   cordic_type front_ff, front_in;
   logic       front_ready;

   logic       cv [N+1];
   cordic_type cd [N+1];
   logic       cr [N+1];
   logic       mat_ready;

   // angle to Q30, one reduction by pi, direction = view - position
   logic signed [33:0] z0;
   always_comb begin
      z0 = 34'(req_data.turn_angle) <<< 17;
      front_in.x    = Q30_GAIN;
      front_in.y    = '0;
      front_in.flip = 1'b0;
      front_in.z    = z0;
      if (z0 > Q30_HALF_PI) begin
         front_in.z    = z0 - Q30_PI;
         front_in.flip = 1'b1;
      end else if (z0 < -Q30_HALF_PI) begin
         front_in.z    = z0 + Q30_PI;
         front_in.flip = 1'b1;
      end
      front_in.a[0] = req_data.axis_x;
      front_in.a[1] = req_data.axis_y;
      front_in.a[2] = req_data.axis_z;
      front_in.p[0] = req_data.pos_x;
      front_in.p[1] = req_data.pos_y;
      front_in.p[2] = req_data.pos_z;
      front_in.d[0] = 33'(req_data.view_x) - 33'(req_data.pos_x);
      front_in.d[1] = 33'(req_data.view_y) - 33'(req_data.pos_y);
      front_in.d[2] = 33'(req_data.view_z) - 33'(req_data.pos_z);
   end

   assign front_ready = !front_valid_ff || cr[0];
   assign req_stall   = !front_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (front_ready) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (front_ready && req_valid) begin
         front_ff <= front_in;
      end
   end

   assign cv[0] = front_valid_ff;
   assign cd[0] = front_ff;
   assign cr[N] = mat_ready;

   // CORDIC chain, one iteration per cell
   for (genvar i = 0; i < N; i++) begin : g_cell
      avr_cordic_cell #(.STAGE(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (cv[i]),
         .in_data    (cd[i]),
         .up_ready   (cr[i]),
         .out_valid  (cv[i+1]),
         .out_data   (cd[i+1]),
         .down_ready (cr[i+1])
      );
   end

   avr_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cv[N]),
      .in_data   (cd[N]),
      .up_ready  (mat_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );
endmodule

>>> design/avr_checker.sv
module avr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input avr_pkg::rsp_type rsp_data
);
   import avr_pkg::*;

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // reset leaves nothing pending and the input open
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state after reset");

   // with the output empty the pipeline must take requests
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   // an open output means the input cannot be stalled in the same cycle
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while output drains");

   // saturation flag implies a clamped component
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.new_view_x == 32'h7fffffff || rsp_data.new_view_x == 32'h80000000 ||
          rsp_data.new_view_y == 32'h7fffffff || rsp_data.new_view_y == 32'h80000000 ||
          rsp_data.new_view_z == 32'h7fffffff || rsp_data.new_view_z == 32'h80000000))
      else $error("saturated flag without clamp");
endmodule

bind axis_angle_vector_rotate_top avr_checker u_avr_checker (.*);

>>> dv/axis_angle_vector_rotate_top_tb.sv
`timescale 1ns / 100ps

module axis_angle_vector_rotate_top_tb;
   import avr_pkg::*;

   localparam int STAGES  = 16;
   localparam int LATENCY = STAGES + 6;
   localparam int N_RAND  = 850;

   typedef logic signed [95:0] wide_type;

   // arctangent steps in Q30
   localparam longint ATAN_STEP [32] = '{
      843314857, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
      127, 63, 31, 15, 8, 4, 2, 1, 0};

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_views[$];
   int      error_count = 0;
   bit      stimulus_done = 1'b0;

   axis_angle_vector_rotate_top #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // round half up, then arithmetic shift
   function automatic wide_type round_shift(wide_type v, int n);
      wide_type half;
      half = wide_type'(1) <<< (n - 1);
      return (v + half) >>> n;
   endfunction

   // rotated view point: P + R*(V - P), saturated
   function automatic rsp_type rotate_view(req_type q);
      longint   z, x, y, dx, dy;
      bit       flip;
      wide_type c, s, t, acc, res;
      wide_type ax[3], dir[3], pos[3], rs[3];
      wide_type m[3][3];
      logic [31:0] outv[3];
      bit       hit;
      rsp_type  r;
      flip = 1'b0;
      hit  = 1'b0;
      ax[0] = wide_type'(q.axis_x);
      ax[1] = wide_type'(q.axis_y);
      ax[2] = wide_type'(q.axis_z);
      pos[0] = wide_type'(q.pos_x);
      pos[1] = wide_type'(q.pos_y);
      pos[2] = wide_type'(q.pos_z);
      dir[0] = wide_type'(q.view_x) - pos[0];
      dir[1] = wide_type'(q.view_y) - pos[1];
      dir[2] = wide_type'(q.view_z) - pos[2];
      // angle reduction into +/- pi/2, then CORDIC
      z = longint'(q.turn_angle) * 131072;
      x = 652032874;
      y = 0;
      if (z > 1686629713) begin
         z = z - 64'sd3373259426;
         flip = 1'b1;
      end else if (z < -1686629713) begin
         z = z + 64'sd3373259426;
         flip = 1'b1;
      end
      for (int i = 0; i < STAGES && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
         end else begin
            x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
         end
      end
      c = flip ? wide_type'(-x) : wide_type'(x);
      s = flip ? wide_type'(-y) : wide_type'(y);
      t = wide_type'(1073741824) - c;
      // rotation matrix in Q30
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            m[i][k] = round_shift(round_shift(t * ax[i], 14) * ax[k], 14);
      for (int i = 0; i < 3; i++) begin
         m[i][i] = m[i][i] + c;
         rs[i] = round_shift(ax[i] * s, 14);
      end
      m[0][1] = m[0][1] - rs[2]; m[1][0] = m[1][0] + rs[2];
      m[0][2] = m[0][2] + rs[1]; m[2][0] = m[2][0] - rs[1];
      m[1][2] = m[1][2] - rs[0]; m[2][1] = m[2][1] + rs[0];
      // product, offset and clamp
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int k = 0; k < 3; k++)
            acc = acc + round_shift(m[i][k], 5) * dir[k];
         res = round_shift(acc, 25) + pos[i];
         if (res > wide_type'(64'sd2147483647)) begin
            hit = 1'b1; res = wide_type'(64'sd2147483647);
         end else if (res < wide_type'(-64'sd2147483648)) begin
            hit = 1'b1; res = wide_type'(-64'sd2147483648);
         end
         outv[i] = res[31:0];
      end
      r.new_view_x = outv[0];
      r.new_view_y = outv[1];
      r.new_view_z = outv[2];
      r.saturated  = hit;
      return r;
   endfunction

   task automatic queue_item(logic [15:0] ang, logic [15:0] ax, logic [15:0] ay,
                             logic [15:0] az, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz, logic [31:0] px, logic [31:0] py,
                             logic [31:0] pz);
      req_type q;
      q.turn_angle = ang; q.axis_x = ax; q.axis_y = ay; q.axis_z = az;
      q.view_x = vx; q.view_y = vy; q.view_z = vz;
      q.pos_x = px; q.pos_y = py; q.pos_z = pz;
      pending_reqs.push_back(q);
   endtask

   // unit axis in Q2.14 from a random direction
   task automatic queue_unit_axis_item(logic [15:0] ang, logic [31:0] vx,
                                       logic [31:0] vy, logic [31:0] vz,
                                       logic [31:0] px, logic [31:0] py,
                                       logic [31:0] pz);
      real fx, fy, fz, len;
      fx = real'($urandom_range(2000)) - 1000.0;
      fy = real'($urandom_range(2000)) - 1000.0;
      fz = real'($urandom_range(2000)) - 1000.0;
      len = $sqrt(fx * fx + fy * fy + fz * fz);
      if (len < 1.0) begin
         fx = 1.0; len = 1.0;
      end
      queue_item(ang, 16'($rtoi(fx / len * 16384.0)), 16'($rtoi(fy / len * 16384.0)),
                 16'($rtoi(fz / len * 16384.0)), vx, vy, vz, px, py, pz);
   endtask

   // stimulus: directed corners, then mostly unit axes with random content
   initial begin
      logic [31:0] px, py, pz;
      int          pick;
      // zero angle and the two angle extremes
      queue_item(16'h0000, 16'sd16384, 16'h0, 16'h0, 32'h0001_0000, 32'h0002_0000,
                 32'h0003_0000, 32'h0, 32'h0, 32'h0);
      queue_item(16'h7FFF, 16'h0, 16'h0, 16'sd16384, 32'h0001_0000, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(16'h8000, 16'h0, 16'sd16384, 16'h0, 32'h0, 32'h0,
                 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      // around +/- pi/2 where the reduction switches
      queue_item(16'sd12867, 16'sd16384, 16'h0, 16'h0, 32'h0, 32'h0001_0000,
                 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(16'sd12868, 16'sd16384, 16'h0, 16'h0, 32'h0, 32'h0001_0000,
                 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(-16'sd12867, 16'h0, 16'h0, 16'sd16384, 32'h0001_0000, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
      queue_item(-16'sd12868, 16'h0, 16'h0, 16'sd16384, 32'h0001_0000, 32'h0,
                 32'h0, 32'h0, 32'h0, 32'h0);
      // non-unit axes at the extremes
      queue_item(16'sd6000, 16'h8000, 16'h8000, 16'h8000, 32'h0100_0000, 32'h0,
                 32'hFF00_0000, 32'h0, 32'h0, 32'h0);
      queue_item(16'sd20000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000);
      queue_item(16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h7FFF_FFFF);
      queue_item(16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000, 32'hFFFF_FFFF, 32'h1,
                 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1);
      // overflow both ways
      queue_item(16'h0000, 16'sd16384, 16'h0, 16'h0, 32'h7FFF_FFFF, 32'h0, 32'h0,
                 32'h8000_0000, 32'h0, 32'h0);
      queue_item(16'sd25736, 16'h0, 16'h0, 16'sd16384, 32'h7000_0000, 32'h7000_0000,
                 32'h0, 32'h7FFF_0000, 32'h7FFF_0000, 32'h0);
      queue_item(16'sd25736, 16'h0, 16'h0, 16'sd16384, 32'h9000_0000, 32'h9000_0000,
                 32'h0, 32'h8001_0000, 32'h8001_0000, 32'h0);
      queue_item(16'hFFFF, 16'h0, 16'sd16384, 16'h0, 32'h0, 32'h0, 32'h0,
                 32'h0, 32'h0, 32'h0);
      queue_item(16'h0001, 16'sd9459, 16'sd9459, 16'sd9459, 32'h0005_0000,
                 32'hFFFA_0000, 32'h0003_8000, 32'h0001_0000, 32'h0, 32'hFFFF_0000);
      // random: mostly unit axes and moderate distances, some full noise
      for (int n = 0; n < N_RAND; n++) begin
         pick = $urandom_range(99);
         px = $urandom(); py = $urandom(); pz = $urandom();
         if (pick < 60) begin
            queue_unit_axis_item(16'($urandom()), px + 32'($signed($urandom_range(
                  2000000)) - 1000000), py + 32'($signed($urandom_range(2000000))
                  - 1000000), pz + 32'($signed($urandom_range(2000000)) - 1000000),
                  px, py, pz);
         end else if (pick < 80) begin
            queue_unit_axis_item(16'($urandom()), $urandom(), $urandom(), $urandom(),
                                 px, py, pz);
         end else begin
            queue_item(16'($urandom()), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), $urandom(), $urandom(), $urandom(),
                       px, py, pz);
         end
      end
      stimulus_done = 1'b1;
   end

   // reset
   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: bursts of transactions with random gaps
   int burst_left = 8;
   int gap_left = 0;
   always @(posedge clock) begin
      bit      take_next;
      req_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take_next = 1'b0;
         if (req_valid && !req_stall)
            expected_views.push_back(rotate_view(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
            end else if (pending_reqs.size() > 0) begin
               take_next = 1'b1;
               burst_left = burst_left - 1;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            if (take_next) begin
               q = pending_reqs.pop_front();
               req_data <= q;
            end
            req_valid <= take_next;
         end
      end
   end

   // receiver stall pattern in randomly drawn modes
   int stall_mode = 0;
   int stall_cycle = 0;
   always @(posedge clock) begin
      stall_cycle = stall_cycle + 1;
      if (stall_cycle % 64 == 0)
         stall_mode = $urandom_range(3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(9) < 3);
         2: rsp_stall <= ($urandom_range(9) < 8);
         default: rsp_stall <= ((stall_cycle / 5) % 2 == 1);
      endcase
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count++;
         end else begin
            want = expected_views.pop_front();
            if (rsp_data.new_view_x !== want.new_view_x) begin
               $display("%0t: new_view_x expected %h actual %h", $time,
                        want.new_view_x, rsp_data.new_view_x);
               error_count++;
            end
            if (rsp_data.new_view_y !== want.new_view_y) begin
               $display("%0t: new_view_y expected %h actual %h", $time,
                        want.new_view_y, rsp_data.new_view_y);
               error_count++;
            end
            if (rsp_data.new_view_z !== want.new_view_z) begin
               $display("%0t: new_view_z expected %h actual %h", $time,
                        want.new_view_z, rsp_data.new_view_z);
               error_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        want.saturated, rsp_data.saturated);
               error_count++;
            end
         end
      end
   end

   // end of test
   initial begin
      @(posedge clock);
      while (!stimulus_done || pending_reqs.size() > 0 || req_valid ||
             expected_views.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_views.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
